[rtl/vnr_pkg.sv]
// Shared constants, types and helpers for the vector normalize and reflect unit.
`timescale 1ns / 1ps

package vnr_pkg;

  // Width of every coordinate on the ports.
  localparam int DATA_W = 32;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Width of the exact sum of squares and of its square root.
  localparam int SUMSQ_W = 2 * DATA_W;
  localparam int ROOT_W = DATA_W;

  // One result bit of the square root is settled per pipeline stage.
  localparam int SQRT_STAGES = ROOT_W;

  typedef logic signed [DATA_W-1:0] coord_t;
  typedef logic [DATA_W-1:0] umag_t;

  // Magnitude of a signed coordinate; the most negative value fits unsigned.
  function automatic umag_t mag32(input coord_t v);
    umag_t m;
    m = v[DATA_W-1] ? umag_t'(-v) : umag_t'(v);
    return m;
  endfunction

endpackage

[rtl/vector_normalize_reflect_unit.sv]
// Top level: normalizes a vector and reflects it about an unnormalized normal.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       request    in_valid / in_stall  in_vec_x/y/z, in_norm_x/y/z
// out_      result     out_valid/out_stall  out_refl_x/y/z, out_zero_length, out_overflowed
//
// One request enters per cycle unless the pipeline is stalled; with FRAC_BITS fraction bits
// (16 at Q16.16) the path runs through three stages of squares and sum, 32 square root
// stages, FRAC_BITS + 1 divider stages and four stages of dot product, scaling and saturation.
// Reset clears only the valid bits; the data path registers are not reset.
// A stalled result freezes the whole pipeline, and in_stall rises in the same cycle.

module vector_normalize_reflect_unit #(
  parameter int FRAC_BITS = vnr_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vnr_pkg::coord_t      in_vec_x,
  input  vnr_pkg::coord_t      in_vec_y,
  input  vnr_pkg::coord_t      in_vec_z,
  input  vnr_pkg::coord_t      in_norm_x,
  input  vnr_pkg::coord_t      in_norm_y,
  input  vnr_pkg::coord_t      in_norm_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vnr_pkg::coord_t      out_refl_x,
  output vnr_pkg::coord_t      out_refl_y,
  output vnr_pkg::coord_t      out_refl_z,
  output logic                 out_zero_length,
  output logic                 out_overflowed
);

  localparam int DW     = vnr_pkg::DATA_W;
  localparam int SW     = vnr_pkg::SUMSQ_W;
  localparam int RW     = vnr_pkg::ROOT_W;
  localparam int SIDE_W = 6 * DW;
  localparam int DIV_N  = FRAC_BITS + 1;
  localparam int U_W    = FRAC_BITS + 2;
  localparam int PROD_W = DW + U_W;
  localparam int DSUM_W = PROD_W + 2;
  localparam int D_W    = DW + 2;
  localparam int DM_W   = D_W - 1;
  localparam int PM_W   = DW + DM_W;
  localparam int R_W    = PM_W + 2;
  localparam int DL_W   = 3 * DW + 1;

  localparam logic signed [DSUM_W-1:0] TRUNC_ADJ = DSUM_W'((65'(1) << FRAC_BITS) - 65'(1));
  localparam logic signed [R_W-1:0] OUT_MAX = R_W'(64'sd2147483647);
  localparam logic signed [R_W-1:0] OUT_MIN = -R_W'(64'sd2147483648);

  logic en;

  // The whole pipeline moves unless a finished result is held back.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: capture the request.
  vnr_pkg::coord_t v1_r [3];
  vnr_pkg::coord_t n1_r [3];
  logic            vld1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r[0] <= in_vec_x;
      v1_r[1] <= in_vec_y;
      v1_r[2] <= in_vec_z;
      n1_r[0] <= in_norm_x;
      n1_r[1] <= in_norm_y;
      n1_r[2] <= in_norm_z;
    end
  end

  // Stage 2: square the magnitude of each vector component.
  vnr_pkg::coord_t v2_r  [3];
  vnr_pkg::coord_t n2_r  [3];
  logic [SW-1:0]   sq2_r [3];
  logic            vld2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v2_r[i]  <= v1_r[i];
        n2_r[i]  <= n1_r[i];
        sq2_r[i] <= SW'(vnr_pkg::mag32(v1_r[i])) * SW'(vnr_pkg::mag32(v1_r[i]));
      end
    end
  end

  // Stage 3: exact sum of squares, below 2^64.
  vnr_pkg::coord_t v3_r [3];
  vnr_pkg::coord_t n3_r [3];
  logic [SW-1:0]   s3_r;
  logic            vld3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v3_r[i] <= v2_r[i];
        n3_r[i] <= n2_r[i];
      end
      s3_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // Length of the vector.
  logic              sq_vld;
  logic [RW-1:0]     len;
  logic [SIDE_W-1:0] sq_side;

  vnr_sqrt_pipe #(
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld3_r),
    .s_i    (s3_r),
    .side_i ({v3_r[0], v3_r[1], v3_r[2], n3_r[0], n3_r[1], n3_r[2]}),
    .vld_o  (sq_vld),
    .root_o (len),
    .side_o (sq_side)
  );

  vnr_pkg::coord_t sv [3];
  logic            zero_len;

  always_comb begin
    sv[0]    = sq_side[6*DW-1:5*DW];
    sv[1]    = sq_side[5*DW-1:4*DW];
    sv[2]    = sq_side[4*DW-1:3*DW];
    zero_len = (len == '0);
  end

  // Divide each component by the length.
  logic signed [U_W-1:0] quot [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vnr_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk    (clk),
      .en     (en),
      .mag_i  (vnr_pkg::mag32(sv[i])),
      .neg_i  (sv[i][DW-1]),
      .len_i  (len),
      .quot_o (quot[i])
    );
  end

  // Delay line for the normal, the zero flag and the valid bit beside the dividers.
  logic [DL_W-1:0] dl_r   [DIV_N];
  logic            dlv_r  [DIV_N];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= {sq_side[3*DW-1:0], zero_len};
      for (int k = 1; k < DIV_N; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_N; k++) begin
        dlv_r[k] <= 1'b0;
      end
    end else if (en) begin
      dlv_r[0] <= sq_vld;
      for (int k = 1; k < DIV_N; k++) begin
        dlv_r[k] <= dlv_r[k-1];
      end
    end
  end

  vnr_pkg::coord_t       dn   [3];
  logic                  dz;
  logic signed [U_W-1:0] uval [3];

  // A zero-length vector keeps u equal to v, which is zero.
  always_comb begin
    dn[0] = dl_r[DIV_N-1][DL_W-1:2*DW+1];
    dn[1] = dl_r[DIV_N-1][2*DW:DW+1];
    dn[2] = dl_r[DIV_N-1][DW:1];
    dz    = dl_r[DIV_N-1][0];
    for (int i = 0; i < 3; i++) begin
      uval[i] = dz ? '0 : quot[i];
    end
  end

  // Stage A: products of normal and unit vector.
  vnr_pkg::coord_t          na_r    [3];
  logic signed [U_W-1:0]    ua_r    [3];
  logic signed [PROD_W-1:0] proda_r [3];
  logic                     za_r;
  logic                     vlda_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        na_r[i]    <= dn[i];
        ua_r[i]    <= uval[i];
        proda_r[i] <= PROD_W'(dn[i]) * PROD_W'(uval[i]);
      end
      za_r <= dz;
    end
  end

  // Stage B: dot product, truncated toward zero after the fraction shift.
  logic signed [DSUM_W-1:0] dsum;
  logic signed [DSUM_W-1:0] dsum_adj;
  vnr_pkg::coord_t          nb_r [3];
  logic signed [U_W-1:0]    ub_r [3];
  logic signed [D_W-1:0]    db_r;
  logic                     zb_r;
  logic                     vldb_r;

  always_comb begin
    dsum     = DSUM_W'(proda_r[0]) + DSUM_W'(proda_r[1]) + DSUM_W'(proda_r[2]);
    dsum_adj = dsum[DSUM_W-1] ? dsum + TRUNC_ADJ : dsum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nb_r[i] <= na_r[i];
        ub_r[i] <= ua_r[i];
      end
      db_r <= D_W'(dsum_adj >>> FRAC_BITS);
      zb_r <= za_r;
    end
  end

  // Stage C: magnitude products of normal and dot product.
  logic [D_W-1:0]        dmag_full;
  logic [DM_W-1:0]       dmag;
  logic [PM_W-1:0]       pmc_r  [3];
  logic                  negc_r [3];
  logic signed [U_W-1:0] uc_r   [3];
  logic                  zc_r;
  logic                  vldc_r;

  always_comb begin
    dmag_full = db_r[D_W-1] ? D_W'(-db_r) : D_W'(db_r);
    dmag      = dmag_full[DM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pmc_r[i]  <= PM_W'(vnr_pkg::mag32(nb_r[i])) * PM_W'(dmag);
        negc_r[i] <= nb_r[i][DW-1] ^ db_r[D_W-1];
        uc_r[i]   <= ub_r[i];
      end
      zc_r <= zb_r;
    end
  end

  // Stage D: fold in the factor two, subtract u and saturate.
  logic signed [R_W-1:0] pval [3];
  logic signed [R_W-1:0] rval [3];
  vnr_pkg::coord_t       rsat [3];
  logic                  ovf;
  vnr_pkg::coord_t       refl_r [3];
  logic                  zero_r;
  logic                  ovf_r;
  logic                  vldd_r;

  always_comb begin
    ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pval[i] = $signed(R_W'(pmc_r[i] >> (FRAC_BITS - 1)));
      if (negc_r[i]) begin
        pval[i] = -pval[i];
      end
      rval[i] = pval[i] - R_W'(uc_r[i]);
      if (rval[i] > OUT_MAX) begin
        rsat[i] = DW'(OUT_MAX);
        ovf     = 1'b1;
      end else if (rval[i] < OUT_MIN) begin
        rsat[i] = DW'(OUT_MIN);
        ovf     = 1'b1;
      end else begin
        rsat[i] = DW'(rval[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        refl_r[i] <= rsat[i];
      end
      zero_r <= zc_r;
      ovf_r  <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlda_r <= 1'b0;
      vldb_r <= 1'b0;
      vldc_r <= 1'b0;
      vldd_r <= 1'b0;
    end else if (en) begin
      vlda_r <= dlv_r[DIV_N-1];
      vldb_r <= vlda_r;
      vldc_r <= vldb_r;
      vldd_r <= vldc_r;
    end
  end

  assign out_valid       = vldd_r;
  assign out_refl_x      = refl_r[0];
  assign out_refl_y      = refl_r[1];
  assign out_refl_z      = refl_r[2];
  assign out_zero_length = zero_r;
  assign out_overflowed  = ovf_r;

endmodule

[rtl/vnr_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage, with a sideband carried along.
`timescale 1ns / 1ps

module vnr_sqrt_pipe #(
  parameter int SIDE_W = 6 * vnr_pkg::DATA_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic [vnr_pkg::SUMSQ_W-1:0]  s_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         vld_o,
  output logic [vnr_pkg::ROOT_W-1:0]   root_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam int N = vnr_pkg::SQRT_STAGES;
  localparam int SW = vnr_pkg::SUMSQ_W;
  localparam int RW = vnr_pkg::ROOT_W;
  localparam int REM_W = RW + 2;
  localparam int EXT_W = REM_W + 2;

  logic [SW-1:0]     s_r    [N];
  logic [REM_W-1:0]  rem_r  [N];
  logic [RW-1:0]     root_r [N];
  logic [SIDE_W-1:0] side_r [N];
  logic              vld_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [SW-1:0]     s_prev;
    logic [REM_W-1:0]  rem_prev;
    logic [RW-1:0]     root_prev;
    logic [SIDE_W-1:0] side_prev;
    logic              vld_prev;
    logic [EXT_W-1:0]  rem_sh;
    logic [EXT_W-1:0]  trial;
    logic              ge;
    logic [EXT_W-1:0]  rem_sub;

    if (k == 0) begin : g_first
      assign s_prev    = s_i;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign side_prev = side_i;
      assign vld_prev  = vld_i;
    end else begin : g_next
      assign s_prev    = s_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign side_prev = side_r[k-1];
      assign vld_prev  = vld_r[k-1];
    end

    // Bring down the next pair of bits and try the digit one.
    always_comb begin
      rem_sh  = {rem_prev, s_prev[SW-1:SW-2]};
      trial   = EXT_W'({root_prev, 2'b01});
      ge      = (rem_sh >= trial);
      rem_sub = rem_sh - trial;
    end

    // Payload advances with the pipeline enable.
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k]    <= s_prev << 2;
        rem_r[k]  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_r[k] <= {root_prev[RW-2:0], ge};
        side_r[k] <= side_prev;
      end
    end

    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_prev;
      end
    end
  end

  assign vld_o  = vld_r[N-1];
  assign root_o = root_r[N-1];
  assign side_o = side_r[N-1];

endmodule

[rtl/vnr_div_lane.sv]
// Pipelined restoring divider for one component: |v| * 2^FRAC_BITS / len, signed result.
`timescale 1ns / 1ps

module vnr_div_lane #(
  parameter int FRAC_BITS = vnr_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [vnr_pkg::DATA_W-1:0]   mag_i,
  input  logic                         neg_i,
  input  logic [vnr_pkg::ROOT_W-1:0]   len_i,
  output logic signed [FRAC_BITS+1:0]  quot_o
);

  localparam int N = FRAC_BITS + 1;
  localparam int DW = vnr_pkg::DATA_W;
  localparam int LW = vnr_pkg::ROOT_W;

  logic [LW-1:0] rem_r [N];
  logic [N-1:0]  q_r   [N];
  logic [LW-1:0] len_r [N];
  logic          neg_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [LW-1:0] rem_prev;
    logic [N-1:0]  q_prev;
    logic [LW-1:0] len_prev;
    logic          neg_prev;
    logic          bit_in;
    logic [LW:0]   rem_sh;
    logic          ge;
    logic [LW:0]   rem_sub;

    // The shifted dividend has only bit zero of |v| below the initial remainder.
    if (k == 0) begin : g_first
      assign rem_prev = LW'(mag_i[DW-1:1]);
      assign q_prev   = '0;
      assign len_prev = len_i;
      assign neg_prev = neg_i;
      assign bit_in   = mag_i[0];
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign q_prev   = q_r[k-1];
      assign len_prev = len_r[k-1];
      assign neg_prev = neg_r[k-1];
      assign bit_in   = 1'b0;
    end

    // One quotient bit: compare and conditionally subtract.
    always_comb begin
      rem_sh  = {rem_prev, bit_in};
      ge      = (rem_sh >= {1'b0, len_prev});
      rem_sub = rem_sh - {1'b0, len_prev};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_sub[LW-1:0] : rem_sh[LW-1:0];
        q_r[k]   <= {q_prev[N-2:0], ge};
        len_r[k] <= len_prev;
        neg_r[k] <= neg_prev;
      end
    end
  end

  // Apply the sign of the vector component.
  assign quot_o = neg_r[N-1] ? -$signed({1'b0, q_r[N-1]}) : $signed({1'b0, q_r[N-1]});

endmodule

[rtl/vnr_checker.sv]
// Port-level checks of the vector normalize and reflect unit, bound to the top level.
`timescale 1ns / 1ps

module vnr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input vnr_pkg::coord_t out_refl_x,
  input vnr_pkg::coord_t out_refl_y,
  input vnr_pkg::coord_t out_refl_z,
  input logic            out_zero_length,
  input logic            out_overflowed
);

  localparam vnr_pkg::coord_t MAXV = 32'sh7fffffff;
  localparam vnr_pkg::coord_t MINV = 32'sh80000000;

  // A held result stays valid and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_refl_x) && $stable(out_refl_y)
      && $stable(out_refl_z) && $stable(out_zero_length) && $stable(out_overflowed))
    else $error("stalled result changed");

  // A held result blocks new requests.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request accepted while the pipeline is frozen");

  // A zero-length vector reflects to the origin without saturation.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_refl_x == '0 && out_refl_y == '0
      && out_refl_z == '0 && !out_overflowed)
    else $error("zero-length result is not zero");

  // Saturation leaves at least one component at a limit.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |-> out_refl_x == MAXV || out_refl_x == MINV
      || out_refl_y == MAXV || out_refl_y == MINV
      || out_refl_z == MAXV || out_refl_z == MINV)
    else $error("overflow flagged without a saturated component");

endmodule

bind vector_normalize_reflect_unit vnr_checker u_vnr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_refl_x      (out_refl_x),
  .out_refl_y      (out_refl_y),
  .out_refl_z      (out_refl_z),
  .out_zero_length (out_zero_length),
  .out_overflowed  (out_overflowed)
);
